>>> src/dtbo_pkg.sv
// ----------------------------------------------------------------------------
// dtbo_pkg: shared definitions of the depth test and blend output unit
// Frame limits, store geometry, register indexes, the state encoding and the
// arithmetic helpers for the color blend.
// ----------------------------------------------------------------------------
package dtbo_pkg;

    localparam int MAX_WIDTH      = 256;
    localparam int MAX_HEIGHT     = 256;
    localparam int DEPTH_BITS     = 24;
    localparam int COLOR_CHANNELS = 4;
    localparam int CHAN_W         = 8;
    localparam int COLOR_W        = COLOR_CHANNELS * CHAN_W;
    localparam int COORD_W        = 8;
    localparam int CFG_W          = 9;
    localparam int CFG_IDX_W      = 1;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    // One more bit so that the full entry count fits.
    localparam int LIN_W      = ADDR_W + 1;
    localparam int SUM_W      = 2 * CHAN_W;

    localparam logic [CFG_W-1:0] MAX_W_CFG = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H_CFG = CFG_W'(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] RESET_W   = CFG_W'(256);
    localparam logic [CFG_W-1:0] RESET_H   = CFG_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic CMD_FRAGMENT = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    // Reciprocal of 255 scaled by 2^23; exact for any 16-bit dividend.
    localparam logic [SUM_W:0] RECIP_255 = 17'h08081;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = 2 * SUM_W + 1;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgba;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RD     = 5'b00010,
        S_CMP    = 5'b00100,
        S_RESULT = 5'b01000,
        S_CLEAR  = 5'b10000
    } t_state;

    // dst * (255 - a) + src * a, which never exceeds 255 * 255.
    function automatic logic [SUM_W-1:0] blend_sum(
        input logic [CHAN_W-1:0] dst,
        input logic [CHAN_W-1:0] src,
        input logic [CHAN_W-1:0] a
    );
        logic [SUM_W-1:0] inv;
        inv = SUM_W'({CHAN_W{1'b1}} - a);
        return SUM_W'(SUM_W'(dst) * inv + SUM_W'(src) * SUM_W'(a));
    endfunction

    // Truncating divide by 255 through a reciprocal multiply.
    function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] sum);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sum) * PROD_W'(RECIP_255);
        return prod[RECIP_SHIFT +: CHAN_W];
    endfunction

endpackage

>>> src/depth_test_blend_output_unit.sv
// ----------------------------------------------------------------------------
// depth_test_blend_output_unit: depth-tested, alpha-blended raster output
// Keeps an RGBA8 color store and a signed depth store, one entry per pixel,
// and runs fragment and clear commands against them.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as beats on the input channel (i_in_valid, o_in_stall)
// and every command returns exactly one result beat on the output channel
// (o_out_valid, i_out_stall). A fragment beat carries a position, a depth and
// a color; a clear beat carries the fill color and depth and selects which
// stores it fills. The frame size comes from two registers on the write port.
// A fragment inside the frame goes from acceptance to the loading of its result
// through these steps: forming the address, the memory read, the depth compare
// and blend products, and the divide by 255 with the write back. The block only
// then accepts the next beat, so it cannot take a new fragment before the
// read-modify-write on the store memories for the last one is through. A
// fragment outside the frame goes straight to its result. A clear writes one
// entry per cycle; input is stalled throughout.
// Reset sets both frame registers to 256 and empties the output register; the
// store contents stay undefined until software clears them. When the receiver
// stalls, the result stays in the output register and the block still accepts
// and processes one more beat, whose result and any fragment write back wait
// until the output register frees up, so no result is lost.
// ----------------------------------------------------------------------------
module depth_test_blend_output_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [dtbo_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dtbo_pkg::CFG_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_command,
    input  logic [dtbo_pkg::COORD_W-1:0]         i_pixel_x,
    input  logic [dtbo_pkg::COORD_W-1:0]         i_pixel_y,
    input  logic signed [dtbo_pkg::DEPTH_BITS-1:0] i_depth,
    input  logic [dtbo_pkg::CHAN_W-1:0]          i_red,
    input  logic [dtbo_pkg::CHAN_W-1:0]          i_green,
    input  logic [dtbo_pkg::CHAN_W-1:0]          i_blue,
    input  logic [dtbo_pkg::CHAN_W-1:0]          i_alpha,
    input  logic                                 i_clear_color,
    input  logic                                 i_clear_depth,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_depth_passed,
    output logic                                 o_depth_updated,
    output logic                                 o_out_of_range
);

    import dtbo_pkg::*;

    // Frame size registers and their clamped values.
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;

    // Command held for the duration of its processing.
    t_state                  r_state;
    t_state                  n_state;
    logic [ADDR_W-1:0]       r_addr;
    logic [ADDR_W-1:0]       r_cnt;
    logic [ADDR_W-1:0]       r_last;
    logic signed [DEPTH_BITS-1:0] r_depth;
    t_rgba                   r_src;
    logic                    r_clear_color;
    logic                    r_clear_depth;
    logic                    r_oor;
    logic                    r_pass;
    logic [SUM_W-1:0]        r_sum_r;
    logic [SUM_W-1:0]        r_sum_g;
    logic [SUM_W-1:0]        r_sum_b;

    // Output register.
    logic r_out_valid;
    logic r_out_passed;
    logic r_out_updated;
    logic r_out_oor;

    logic in_accept;
    logic out_free;
    logic frag_oor;
    logic [LIN_W-1:0] frag_lin;
    logic [LIN_W-1:0] frame_count;
    logic finish;

    // Memory ports.
    logic                    color_we;
    logic                    depth_we;
    logic [ADDR_W-1:0]       wr_addr;
    t_rgba                   color_wdata;
    t_rgba                   color_rdata;
    logic [DEPTH_BITS-1:0]   depth_rdata;
    t_rgba                   blended;

    // Register values above the store limits saturate to the limit.
    assign eff_w = (r_frame_width  > MAX_W_CFG) ? MAX_W_CFG : r_frame_width;
    assign eff_h = (r_frame_height > MAX_H_CFG) ? MAX_H_CFG : r_frame_height;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Fragment position test and linear address; a zero-sized frame puts every
    // fragment outside.
    assign frag_oor    = (CFG_W'(i_pixel_x) >= eff_w) || (CFG_W'(i_pixel_y) >= eff_h);
    assign frag_lin    = LIN_W'(LIN_W'(i_pixel_y) * LIN_W'(eff_w) + LIN_W'(i_pixel_x));
    assign frame_count = LIN_W'(LIN_W'(eff_w) * LIN_W'(eff_h));

    // The result register is loaded when the last state can hand off its beat.
    assign finish = (r_state == S_RESULT) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_command == CMD_CLEAR) begin
                        n_state = (frame_count == '0) ? S_RESULT : S_CLEAR;
                    end else if (frag_oor) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:     n_state = S_CMP;
            S_CMP:    n_state = S_RESULT;
            S_CLEAR: begin
                if (r_cnt == r_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_frame_width  <= RESET_W;
            r_frame_height <= RESET_H;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command payload, compare results and the output fields.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_addr        <= frag_lin[ADDR_W-1:0];
            r_last        <= ADDR_W'(frame_count - LIN_W'(1));
            r_cnt         <= '0;
            r_depth       <= i_depth;
            r_src         <= '{alpha: i_alpha, blue: i_blue, green: i_green, red: i_red};
            r_clear_color <= i_clear_color;
            r_clear_depth <= i_clear_depth;
            r_oor         <= (i_command == CMD_FRAGMENT) && frag_oor;
            r_pass        <= 1'b0;
        end
        if (r_state == S_CLEAR) begin
            r_cnt <= r_cnt + ADDR_W'(1);
        end
        if (r_state == S_CMP) begin
            // Strictly closer fragments pass.
            r_pass  <= r_depth < $signed(depth_rdata);
            r_sum_r <= blend_sum(color_rdata.red,   r_src.red,   r_src.alpha);
            r_sum_g <= blend_sum(color_rdata.green, r_src.green, r_src.alpha);
            r_sum_b <= blend_sum(color_rdata.blue,  r_src.blue,  r_src.alpha);
        end
        if (finish) begin
            r_out_passed  <= r_pass;
            r_out_updated <= r_pass && r_src.alpha[CHAN_W-1];
            r_out_oor     <= r_oor;
        end
    end

    // An opaque fragment gives src * 255 / 255, so the blend needs no bypass.
    assign blended = '{alpha: r_src.alpha,
                       blue:  div255(r_sum_b),
                       green: div255(r_sum_g),
                       red:   div255(r_sum_r)};

    assign wr_addr     = (r_state == S_CLEAR) ? r_cnt : r_addr;
    assign color_wdata = (r_state == S_CLEAR) ? r_src : blended;
    assign color_we    = ((r_state == S_CLEAR) && r_clear_color) || (finish && r_pass);
    // Depth is only kept for fragments at least half opaque.
    assign depth_we    = ((r_state == S_CLEAR) && r_clear_depth) ||
                         (finish && r_pass && r_src.alpha[CHAN_W-1]);

    dtbo_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_SIZE)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (color_we),
        .i_waddr (wr_addr),
        .i_wdata (color_wdata),
        .i_raddr (r_addr),
        .o_rdata (color_rdata)
    );

    dtbo_ram #(
        .WIDTH (DEPTH_BITS),
        .DEPTH (STORE_SIZE)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (depth_we),
        .i_waddr (wr_addr),
        .i_wdata (r_depth),
        .i_raddr (r_addr),
        .o_rdata (depth_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_depth_passed  = r_out_passed;
    assign o_depth_updated = r_out_updated;
    assign o_out_of_range  = r_out_oor;

`ifndef NO_ASSERTIONS
    // The stores are only written by a clear sweep or a fragment write back.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (color_we || depth_we) |-> (r_state == S_CLEAR || r_state == S_RESULT))
        else $error("store written outside clear or write back");

    // The clear sweep never runs past the last entry of the frame.
    a_clear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (r_cnt <= r_last))
        else $error("clear counter beyond frame");

    // An accepted beat always starts processing.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("accepted beat not processed");

    // An outside fragment never reports a pass.
    a_oor_no_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |-> (!o_depth_passed && !o_depth_updated))
        else $error("outside fragment reported as passed");

    // A passing, at least half opaque fragment always writes depth.
    a_update_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && r_pass && r_src.alpha[CHAN_W-1]) |-> depth_we)
        else $error("depth not written on an update");
`endif

endmodule

>>> src/dtbo_ram.sv
// ----------------------------------------------------------------------------
// dtbo_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered, so it
// appears in the cycle after the address. Contents are undefined after reset.
// ----------------------------------------------------------------------------
module dtbo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the depth test and blend output unit
// Drives fragment and clear beats through the valid/stall handshake, keeps a
// private copy of the color and depth stores to work out every verdict, and
// compares each result beat with the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module tb;
    import dtbo_pkg::*;

    // A full-frame clear keeps both channels quiet for its whole sweep, so the
    // watchdog limit lies well above the length of that sweep.
    localparam int QUIET_LIMIT   = 300000;
    // Cycles to wait after the last verdict has been met, to catch strays.
    localparam int TAIL_CYCLES   = 24;
    localparam int RANDOM_ITEMS  = 450;
    localparam int CLEAR_AREA_CAP = 1024;

    localparam logic signed [DEPTH_BITS-1:0] Z_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] Z_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    // One command as it travels on the input channel.
    typedef struct {
        logic                         command;
        logic [COORD_W-1:0]           x;
        logic [COORD_W-1:0]           y;
        logic signed [DEPTH_BITS-1:0] depth;
        logic [CHAN_W-1:0]            red;
        logic [CHAN_W-1:0]            green;
        logic [CHAN_W-1:0]            blue;
        logic [CHAN_W-1:0]            alpha;
        logic                         fill_color;
        logic                         fill_depth;
    } t_beat;

    // The three flags of one result beat.
    typedef struct packed {
        logic passed;
        logic updated;
        logic outside;
    } t_outcome;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]             i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic                         i_command = CMD_FRAGMENT;
    logic [COORD_W-1:0]           i_pixel_x = '0;
    logic [COORD_W-1:0]           i_pixel_y = '0;
    logic signed [DEPTH_BITS-1:0] i_depth = '0;
    logic [CHAN_W-1:0]            i_red = '0;
    logic [CHAN_W-1:0]            i_green = '0;
    logic [CHAN_W-1:0]            i_blue = '0;
    logic [CHAN_W-1:0]            i_alpha = '0;
    logic                         i_clear_color = 1'b0;
    logic                         i_clear_depth = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic                         o_depth_passed;
    logic                         o_depth_updated;
    logic                         o_out_of_range;

    depth_test_blend_output_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_depth         (i_depth),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_alpha         (i_alpha),
        .i_clear_color   (i_clear_color),
        .i_clear_depth   (i_clear_depth),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_depth_passed  (o_depth_passed),
        .o_depth_updated (o_depth_updated),
        .o_out_of_range  (o_out_of_range)
    );

    always #2 i_clk = ~i_clk;

    // The bench's own view of the block: frame registers and both stores.
    logic [CFG_W-1:0]             shadow_w = RESET_W;
    logic [CFG_W-1:0]             shadow_h = RESET_H;
    logic [COLOR_W-1:0]           shadow_color [STORE_SIZE];
    logic signed [DEPTH_BITS-1:0] shadow_depth [STORE_SIZE];

    // Verdicts for accepted beats, oldest first.
    t_outcome pending_outcomes[$];

    // Percentages of cycles in which the sender holds back and the receiver
    // stalls; the main sequence changes them between phases.
    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;

    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned n_fragments = 0;
    int unsigned n_passed = 0;
    int unsigned n_updated = 0;
    int unsigned n_outside = 0;
    int unsigned n_clears = 0;
    int unsigned n_frames = 0;

    // A register above the store limit saturates to that limit.
    function automatic int unsigned frame_extent(input logic [CFG_W-1:0] v, input int unsigned lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    // Truncating blend of one channel with the stored destination.
    function automatic logic [CHAN_W-1:0] blend_chan(
        input logic [CHAN_W-1:0] dst,
        input logic [CHAN_W-1:0] src,
        input logic [CHAN_W-1:0] a
    );
        int unsigned sum;
        sum = int'(dst) * (255 - int'(a)) + int'(src) * int'(a);
        return CHAN_W'(sum / 255);
    endfunction

    // Applies one beat to the shadow stores and returns the flags that the
    // block must answer with.
    function automatic t_outcome raster_outcome(input t_beat b);
        t_outcome          res;
        int unsigned       w;
        int unsigned       h;
        int unsigned       n;
        int unsigned       idx;
        int unsigned       i;
        logic [COLOR_W-1:0] dst;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] bl;
        res = '0;
        w = frame_extent(shadow_w, MAX_WIDTH);
        h = frame_extent(shadow_h, MAX_HEIGHT);
        if (b.command == CMD_CLEAR) begin
            n = w * h;
            for (i = 0; i < n; i++) begin
                if (b.fill_color)
                    shadow_color[i] = {b.alpha, b.blue, b.green, b.red};
                if (b.fill_depth)
                    shadow_depth[i] = b.depth;
            end
        end else if (int'(b.x) >= w || int'(b.y) >= h) begin
            res.outside = 1'b1;
        end else begin
            idx = int'(b.y) * w + int'(b.x);
            if ($signed(b.depth) < $signed(shadow_depth[idx])) begin
                dst = shadow_color[idx];
                r = b.red;
                g = b.green;
                bl = b.blue;
                // An opaque fragment replaces the stored color outright.
                if (b.alpha != 8'hFF) begin
                    r  = blend_chan(dst[7:0],   b.red,   b.alpha);
                    g  = blend_chan(dst[15:8],  b.green, b.alpha);
                    bl = blend_chan(dst[23:16], b.blue,  b.alpha);
                end
                shadow_color[idx] = {b.alpha, bl, g, r};
                res.passed = 1'b1;
                if (b.alpha >= 8'd128) begin
                    shadow_depth[idx] = b.depth;
                    res.updated = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_beat fragment_beat(
        input int unsigned x,
        input int unsigned y,
        input logic signed [DEPTH_BITS-1:0] z,
        input logic [CHAN_W-1:0] a
    );
        t_beat b;
        b.command    = CMD_FRAGMENT;
        b.x          = COORD_W'(x);
        b.y          = COORD_W'(y);
        b.depth      = z;
        b.red        = CHAN_W'($urandom);
        b.green      = CHAN_W'($urandom);
        b.blue       = CHAN_W'($urandom);
        b.alpha      = a;
        // The fill selects mean nothing to a fragment, so they toggle freely.
        b.fill_color = 1'($urandom);
        b.fill_depth = 1'($urandom);
        return b;
    endfunction

    function automatic t_beat clear_beat(
        input logic signed [DEPTH_BITS-1:0] z,
        input logic fc,
        input logic fd
    );
        t_beat b;
        b = fragment_beat($urandom_range(0, 255), $urandom_range(0, 255), z,
                          CHAN_W'($urandom));
        b.command    = CMD_CLEAR;
        b.fill_color = fc;
        b.fill_depth = fd;
        return b;
    endfunction

    // Presents one beat, holds it until the block takes it, then records the
    // verdict. The valid line is left high so that back-to-back beats never
    // see it lowered and raised within one time step.
    task automatic send_beat(input t_beat b);
        t_outcome v;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid    <= 1'b1;
        i_command     <= b.command;
        i_pixel_x     <= b.x;
        i_pixel_y     <= b.y;
        i_depth       <= b.depth;
        i_red         <= b.red;
        i_green       <= b.green;
        i_blue        <= b.blue;
        i_alpha       <= b.alpha;
        i_clear_color <= b.fill_color;
        i_clear_depth <= b.fill_depth;
        do @(posedge i_clk); while (o_in_stall);
        v = raster_outcome(b);
        pending_outcomes.push_back(v);
        if (b.command == CMD_CLEAR) begin
            n_clears++;
        end else begin
            n_fragments++;
            n_passed  += v.passed;
            n_updated += v.updated;
            n_outside += v.outside;
        end
    endtask

    // Lowers valid and waits until every outstanding result beat is in. Each
    // command yields exactly one result, so the block is idle afterwards.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Writes both frame registers on consecutive cycles. Only called when the
    // block is idle.
    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FRAME_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        shadow_w = w;
        i_cfg_index <= REG_FRAME_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        shadow_h = h;
        i_cfg_we <= 1'b0;
        n_frames++;
    endtask

    // The stores are undefined after reset, so the very first command fills
    // every entry of both at the reset frame size of 256 by 256. From here on
    // no fragment can read an entry that was never written.
    task automatic test_initial_clear;
        send_beat(clear_beat(Z_MAX, 1'b1, 1'b1));
        drain();
    endtask

    // Strict less-than on depth at both extremes, and the alpha threshold
    // that decides whether depth is written along with color.
    task automatic test_depth_compare;
        send_beat(fragment_beat(0, 0, Z_MAX, 8'hFF));       // equal depth fails
        send_beat(fragment_beat(255, 255, Z_MIN, 8'hFF));   // opaque, passes
        send_beat(fragment_beat(255, 255, Z_MIN, 8'h00));   // now equal, fails
        send_beat(fragment_beat(10, 3, '0, 8'd127));        // color only
        send_beat(fragment_beat(10, 3, '0, 8'd128));        // color and depth
        send_beat(fragment_beat(10, 3, -24'sd1, 8'h00));    // fully transparent
        send_beat(fragment_beat(10, 3, '0, 8'hFF));         // equal again, fails
        drain();
    endtask

    // Saturated, single-pixel and zero-sized frames.
    task automatic test_frame_limits;
        set_frame(9'h1FF, 9'd300);
        send_beat(fragment_beat(255, 0, -24'sd5, 8'd200));
        drain();
        set_frame(9'd1, 9'd1);
        send_beat(fragment_beat(0, 0, -24'sd100, 8'hFF));
        send_beat(fragment_beat(1, 0, Z_MIN, 8'hFF));
        send_beat(fragment_beat(0, 1, Z_MIN, 8'hFF));
        send_beat(fragment_beat(255, 255, Z_MIN, 8'hFF));
        drain();
        // A clear over a frame with no width must leave the stores alone.
        set_frame(9'd0, 9'd256);
        send_beat(fragment_beat(0, 0, Z_MIN, 8'hFF));
        send_beat(clear_beat(Z_MIN, 1'b1, 1'b1));
        drain();
        set_frame(9'd256, 9'd0);
        send_beat(fragment_beat(0, 0, Z_MIN, 8'hFF));
        drain();
    endtask

    // A clear only reaches the first W*H entries, and each fill select acts
    // on its own store only.
    task automatic test_clear_extent;
        set_frame(9'd4, 9'd4);
        send_beat(clear_beat(Z_MIN, 1'b0, 1'b1));
        send_beat(fragment_beat(3, 3, '0, 8'hFF));
        send_beat(fragment_beat(0, 0, Z_MIN, 8'hFF));
        drain();
        set_frame(9'd256, 9'd256);
        send_beat(fragment_beat(16, 0, '0, 8'hFF));
        send_beat(fragment_beat(15, 0, '0, 8'hFF));
        send_beat(fragment_beat(100, 100, 24'sd5, 8'hFF));
        drain();
        set_frame(9'd2, 9'd2);
        send_beat(clear_beat(Z_MAX, 1'b1, 1'b0));
        send_beat(fragment_beat(1, 1, '0, 8'hFF));
        drain();
        // Oversized registers: this clear covers the whole 256 by 256 store.
        set_frame(9'd300, 9'h1FF);
        send_beat(clear_beat(Z_MAX, 1'b1, 1'b1));
        drain();
    endtask

    // Random scenes: pick a frame, usually a small one so that pixels are hit
    // again and again, clear it when that is cheap, then draw a run of
    // fragments. Most land inside the frame; the rest are stray positions and
    // the odd clear in the middle of drawing.
    task automatic test_random_scenes(input int unsigned items);
        int unsigned sent;
        int unsigned pick;
        int unsigned run;
        int unsigned w;
        int unsigned h;
        int unsigned area;
        logic [CFG_W-1:0] reg_w;
        logic [CFG_W-1:0] reg_h;
        logic signed [DEPTH_BITS-1:0] z;
        logic [CHAN_W-1:0] a;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                reg_w = CFG_W'($urandom_range(1, 16));
                reg_h = CFG_W'($urandom_range(1, 16));
            end else if (pick < 85) begin
                reg_w = CFG_W'($urandom_range(17, 64));
                reg_h = CFG_W'($urandom_range(1, 64));
            end else if (pick < 95) begin
                reg_w = CFG_W'($urandom_range(1, 511));
                reg_h = CFG_W'($urandom_range(1, 511));
            end else if ($urandom_range(1)) begin
                reg_w = '0;
                reg_h = CFG_W'($urandom_range(0, 511));
            end else begin
                reg_w = CFG_W'($urandom_range(0, 511));
                reg_h = '0;
            end
            set_frame(reg_w, reg_h);
            w = frame_extent(reg_w, MAX_WIDTH);
            h = frame_extent(reg_h, MAX_HEIGHT);
            area = w * h;
            // Clearing to a far depth lets most of the first fragments pass.
            if (area <= CLEAR_AREA_CAP) begin
                send_beat(clear_beat(DEPTH_BITS'($urandom_range(24'h600000, 24'h7FFFFF)),
                                     1'b1, 1'b1));
                sent++;
            end
            run = $urandom_range(10, 40);
            repeat (run) begin
                pick = $urandom_range(99);
                case ($urandom_range(9))
                    0:       z = $urandom_range(1) ? Z_MIN : Z_MAX;
                    1, 2, 3: z = DEPTH_BITS'($urandom);
                    default: z = DEPTH_BITS'(int'($urandom_range(0, 24'h7FFFFF)) - 24'h400000);
                endcase
                case ($urandom_range(9))
                    0, 1, 2: a = 8'hFF;
                    3:       a = 8'h00;
                    4:       a = $urandom_range(1) ? 8'd127 : 8'd128;
                    default: a = CHAN_W'($urandom);
                endcase
                if (pick < 4 && area <= CLEAR_AREA_CAP)
                    send_beat(clear_beat(z, 1'($urandom), 1'($urandom)));
                else if (pick < 14 || area == 0)
                    send_beat(fragment_beat($urandom_range(0, 255), $urandom_range(0, 255), z, a));
                else
                    send_beat(fragment_beat($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                                            z, a));
                sent++;
            end
            drain();
        end
    endtask

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < out_idle_pct);

    // Every result beat is matched against the oldest pending verdict.
    always @(posedge i_clk) begin : check_results
        t_outcome seen;
        t_outcome want;
        if (o_out_valid === 1'b1 && !i_out_stall) begin
            seen = {o_depth_passed, o_depth_updated, o_out_of_range};
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, got %b%b%b",
                         $time, seen.passed, seen.updated, seen.outside);
            end else begin
                want = pending_outcomes.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    $display("%0t: result mismatch (passed updated outside), %s %b%b%b, %s %b%b%b",
                             $time, "expected", want.passed, want.updated, want.outside,
                             "got", seen.passed, seen.updated, seen.outside);
                end
            end
        end
    end

    // Cycles in which neither channel moved a beat; any beat resets the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin : main_sequence
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: a hesitant sender and a receiver that stalls most cycles.
        in_idle_pct  = 36;
        out_idle_pct = 74;
        test_initial_clear();
        test_depth_compare();
        test_frame_limits();
        test_clear_extent();
        test_random_scenes(RANDOM_ITEMS);

        // Phase two: the rates swap sides.
        in_idle_pct  = 74;
        out_idle_pct = 36;
        test_random_scenes(RANDOM_ITEMS);

        // Phase three: both sides at full rate.
        in_idle_pct  = 0;
        out_idle_pct = 0;
        test_random_scenes(RANDOM_ITEMS);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d fragments (%0d passed, %0d wrote depth, %0d outside the frame)",
                 n_fragments, n_passed, n_updated, n_outside);
        $display("tb: %0d clears over %0d frame settings, %0d mismatches",
                 n_clears, n_frames, mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
src/dtbo_pkg.sv
src/dtbo_ram.sv
src/depth_test_blend_output_unit.sv
bench/tb.sv
